[sv/fgn_pkg.sv]
// Shared types and constants of the fractal gradient noise block.
`timescale 1ns / 1ps

package fgn_pkg;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_WB,
		S_TAB,
		S_DIV,
		S_OUT
	} state_t;

	typedef enum logic [3:0] {
		OP_SX,
		OP_SY,
		OP_U2,
		OP_U3,
		OP_UD,
		OP_UF,
		OP_V2,
		OP_V3,
		OP_VD,
		OP_VF,
		OP_LO,
		OP_HI,
		OP_VAL,
		OP_TOT,
		OP_AMP,
		OP_FRQ
	} op_t;

	localparam logic [1:0] REG_OCTAVES     = 2'd0;
	localparam logic [1:0] REG_PERSISTENCE = 2'd1;
	localparam logic [1:0] REG_LACUNARITY  = 2'd2;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_EVAL = 1'b1;

	localparam logic [4:0]  OCTAVES_RESET     = 5'd1;
	localparam logic [15:0] PERSISTENCE_RESET = 16'd2048;
	localparam logic [15:0] LACUNARITY_RESET  = 16'd8192;

	localparam logic [31:0] ONE_Q16 = 32'd65536;
	localparam logic [19:0] FADE_A  = 20'd983040;
	localparam logic [19:0] FADE_B  = 20'd655360;

	localparam logic [2:0] TAB_LAST = 3'd6;

endpackage

[sv/fractal_gradient_noise_2d.sv]
// Top level: fractal gradient noise sequencer around a shared multiplier and divider.
//
//  channel  direction  request content
//  s_*      in         command in tuser; table entry or Q16.16 point in tdata
//  m_*      out        Q1.15 noise value
//  cfg_*    in         register index and write data
//
// Each octave of an evaluation runs sixteen multiplies on the shared multiplier and
// the permutation reads through the table port. The final division computes eighteen
// quotient bits, then hands over to the output load.
// Reset clears the state machine, the output valid and the configuration registers; the table is not cleared.
// The input is refused from the start of an evaluation until its result is in
// the output register, which holds while the output stalls.
`timescale 1ns / 1ps

module fractal_gradient_noise_2d
	import fgn_pkg::*;
#(
	parameter int MAX_OCTAVES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [79:0] s_tdata,  // table_index, table_value, x_coord, y_coord
	input  logic        s_tuser,  // command
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // noise_value
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int LW = $clog2(MAX_OCTAVES + 1);
	localparam int SW = $clog2(MAX_OCTAVES) + 1;
	localparam int TW = 52 + SW;
	localparam int AW = 32 + SW;

	state_t state_q, state_d;

	logic [4:0]  octave_count_q;
	logic [15:0] persistence_q;
	logic [15:0] lacunarity_q;

	logic signed [31:0] x_q, y_q;
	logic [31:0]        freq_q, amp_q, sx_q, sy_q;
	logic [15:0]        t2_q, t3_q;
	logic [19:0]        d_q;
	logic [17:0]        u_q, v_q;
	logic signed [19:0] low_q, high_q, val_q;
	logic signed [TW-1:0] total_q;
	logic [AW-1:0]      ampsum_q;
	logic [1:0]         h00_q, h01_q, h10_q, h11_q;
	logic [7:0]         pa_q, pb_q;
	op_t                op_q;
	logic [2:0]         tab_q;
	logic [LW-1:0]      layer_q, nlay_q;
	logic               m_tvalid_q;
	logic [15:0]        m_tdata_q;

	logic               in_acc, load_acc, eval_acc;
	logic               last_layer, div_start, div_done, out_load;
	logic signed [15:0] div_quot;
	logic [7:0]         raddr, rdata;
	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] prod_q, adj;
	logic signed [19:0] tq;
	logic [15:0]        fx, fy, ft;
	logic [7:0]         xi, yi;
	logic [19:0]        kd;
	logic signed [17:0] dx0, dx1, dy0, dy1;
	logic signed [19:0] n00, n01, n10, n11;
	logic [LW-1:0]      nlay;

	function automatic logic signed [19:0] dot_grad(input logic [1:0] h,
			input logic signed [17:0] dx, input logic signed [17:0] dy);
		logic signed [19:0] gx;
		logic signed [19:0] gy;
		gx = h[0] ? -20'(dx) : 20'(dx);
		gy = h[1] ? -20'(dy) : 20'(dy);
		return gx + gy;
	endfunction

	assign s_tready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign in_acc    = s_tvalid && s_tready;
	assign load_acc  = in_acc && (s_tuser == CMD_LOAD);
	assign eval_acc  = in_acc && (s_tuser == CMD_EVAL);
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;

	assign fx = sx_q[15:0];
	assign fy = sy_q[15:0];
	assign xi = sx_q[23:16];
	assign yi = sy_q[23:16];
	assign ft = (op_q inside {OP_V2, OP_V3, OP_VD, OP_VF}) ? fy : fx;
	assign kd = FADE_A - (20'({ft, 2'b00}) + 20'({ft, 1'b0}));

	assign dx0 = $signed({2'b00, fx});
	assign dy0 = $signed({2'b00, fy});
	assign dx1 = dx0 - 18'sd65536;
	assign dy1 = dy0 - 18'sd65536;
	assign n00 = dot_grad(h00_q, dx0, dy0);
	assign n10 = dot_grad(h10_q, dx1, dy0);
	assign n01 = dot_grad(h01_q, dx0, dy1);
	assign n11 = dot_grad(h11_q, dx1, dy1);

	assign adj = prod_q + (prod_q[65] ? 66'sd65535 : 66'sd0);
	assign tq  = adj[35:16];

	assign last_layer = (layer_q + LW'(1)) == nlay_q;

	always_comb begin
		if (octave_count_q == 5'd0) begin
			nlay = LW'(1);
		end else if (32'(octave_count_q) > MAX_OCTAVES) begin
			nlay = LW'(MAX_OCTAVES);
		end else begin
			nlay = LW'(octave_count_q);
		end
	end

	always_comb begin
		unique case (tab_q)
			3'd0:    raddr = xi;
			3'd1:    raddr = xi + 8'd1;
			3'd2:    raddr = pa_q + yi;
			3'd3:    raddr = pa_q + yi + 8'd1;
			3'd4:    raddr = pb_q + yi;
			3'd5:    raddr = pb_q + yi + 8'd1;
			default: raddr = xi;
		endcase
	end

	always_comb begin
		case (op_q)
			OP_SX: begin
				mul_a = 33'(x_q);
				mul_b = $signed({1'b0, freq_q});
			end
			OP_SY: begin
				mul_a = 33'(y_q);
				mul_b = $signed({1'b0, freq_q});
			end
			OP_U2, OP_V2: begin
				mul_a = $signed({17'd0, ft});
				mul_b = $signed({17'd0, ft});
			end
			OP_U3, OP_V3: begin
				mul_a = $signed({17'd0, t2_q});
				mul_b = $signed({17'd0, ft});
			end
			OP_UD, OP_VD: begin
				mul_a = $signed({13'd0, kd});
				mul_b = $signed({17'd0, ft});
			end
			OP_UF, OP_VF: begin
				mul_a = $signed({17'd0, t3_q});
				mul_b = $signed({13'd0, FADE_B - d_q});
			end
			OP_LO: begin
				mul_a = $signed({15'd0, u_q});
				mul_b = 33'(n10 - n00);
			end
			OP_HI: begin
				mul_a = $signed({15'd0, u_q});
				mul_b = 33'(n11 - n01);
			end
			OP_VAL: begin
				mul_a = $signed({15'd0, v_q});
				mul_b = 33'(high_q - low_q);
			end
			OP_TOT: begin
				mul_a = 33'(val_q);
				mul_b = $signed({1'b0, amp_q});
			end
			OP_AMP: begin
				mul_a = $signed({1'b0, amp_q});
				mul_b = $signed({17'd0, persistence_q});
			end
			default: begin
				mul_a = $signed({1'b0, freq_q});
				mul_b = $signed({17'd0, lacunarity_q});
			end
		endcase
	end

	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (eval_acc) begin
					state_d = S_MUL;
				end
			end
			S_MUL: begin
				state_d = S_WB;
			end
			S_WB: begin
				if (op_q == OP_SY) begin
					state_d = S_TAB;
				end else if (op_q == OP_FRQ && last_layer) begin
					state_d   = S_DIV;
					div_start = 1'b1;
				end else begin
					state_d = S_MUL;
				end
			end
			S_TAB: begin
				if (tab_q == TAB_LAST) begin
					state_d = S_MUL;
				end
			end
			S_DIV: begin
				if (div_done) begin
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				if (!m_tvalid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			m_tvalid_q     <= 1'b0;
			octave_count_q <= OCTAVES_RESET;
			persistence_q  <= PERSISTENCE_RESET;
			lacunarity_q   <= LACUNARITY_RESET;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_OCTAVES:     octave_count_q <= cfg_data[4:0];
					REG_PERSISTENCE: persistence_q  <= cfg_data;
					REG_LACUNARITY:  lacunarity_q   <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= div_quot;
		end
		if (eval_acc) begin
			x_q      <= $signed(s_tdata[47:16]);
			y_q      <= $signed(s_tdata[79:48]);
			freq_q   <= ONE_Q16;
			amp_q    <= ONE_Q16;
			total_q  <= '0;
			ampsum_q <= '0;
			layer_q  <= '0;
			nlay_q   <= nlay;
			op_q     <= OP_SX;
			tab_q    <= '0;
		end
		if (state_q == S_TAB) begin
			tab_q <= tab_q + 3'd1;
			case (tab_q)
				3'd1: pa_q  <= rdata;
				3'd2: pb_q  <= rdata;
				3'd3: h00_q <= rdata[1:0];
				3'd4: h01_q <= rdata[1:0];
				3'd5: h10_q <= rdata[1:0];
				3'd6: h11_q <= rdata[1:0];
				default: ;
			endcase
		end
		if (state_q == S_WB) begin
			op_q <= op_t'(op_q + 4'd1);
			case (op_q)
				OP_SX:        sx_q   <= prod_q[47:16];
				OP_SY: begin
					sy_q  <= prod_q[47:16];
					tab_q <= '0;
				end
				OP_U2, OP_V2: t2_q   <= prod_q[31:16];
				OP_U3, OP_V3: t3_q   <= prod_q[31:16];
				OP_UD, OP_VD: d_q    <= prod_q[35:16];
				OP_UF:        u_q    <= prod_q[33:16];
				OP_VF:        v_q    <= prod_q[33:16];
				OP_LO:        low_q  <= n00 + tq;
				OP_HI:        high_q <= n01 + tq;
				OP_VAL:       val_q  <= low_q + tq;
				OP_TOT: begin
					total_q  <= total_q + TW'($signed(prod_q[51:0]));
					ampsum_q <= ampsum_q + AW'(amp_q);
				end
				OP_AMP:       amp_q  <= (|prod_q[47:44]) ? '1 : prod_q[43:12];
				default: begin
					freq_q  <= (|prod_q[47:44]) ? '1 : prod_q[43:12];
					layer_q <= layer_q + LW'(1);
				end
			endcase
		end
	end

	fgn_perm_ram u_ram (
		.clk   (clk),
		.we    (load_acc),
		.waddr (s_tdata[7:0]),
		.wdata (s_tdata[15:8]),
		.raddr (raddr),
		.rdata (rdata)
	);

	fgn_mul u_mul (
		.clk    (clk),
		.en     (state_q == S_MUL),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod_q)
	);

	fgn_div #(
		.NW (TW),
		.DW (AW + 1)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (total_q),
		.divisor  ({ampsum_q, 1'b0}),
		.done     (div_done),
		.quot     (div_quot)
	);

endmodule

[sv/fgn_perm_ram.sv]
// Permutation table: 256 bytes, one write port and one registered read port.
`timescale 1ns / 1ps

module fgn_perm_ram (
	input  logic       clk,
	input  logic       we,
	input  logic [7:0] waddr,
	input  logic [7:0] wdata,
	input  logic [7:0] raddr,
	output logic [7:0] rdata
);

	logic [7:0] mem [256];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[sv/fgn_mul.sv]
// Shared signed 33 by 33 multiplier with a registered product.
`timescale 1ns / 1ps

module fgn_mul (
	input  logic               clk,
	input  logic               en,
	input  logic signed [32:0] a,
	input  logic signed [32:0] b,
	output logic signed [65:0] prod_q
);

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= a * b;
		end
	end

endmodule

[sv/fgn_div.sv]
// Restoring divider, one quotient bit a cycle, with a saturated signed 16-bit result.
`timescale 1ns / 1ps

module fgn_div #(
	parameter int NW = 58,
	parameter int DW = 39
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [NW-1:0] dividend,
	input  logic [DW-1:0]        divisor,
	output logic                 done,
	output logic signed [15:0]   quot
);

	localparam int QW = 18;
	localparam int CW = (NW > DW + QW) ? NW : DW + QW;
	localparam int KW = $clog2(QW + 1);

	logic [NW-1:0]      rem_q;
	logic [DW+QW-2:0]   den_q;
	logic [QW-1:0]      q_q;
	logic [KW-1:0]      cnt_q;
	logic               neg_q;
	logic               run_q;
	logic               done_q;
	logic [CW-1:0]      rem_x;
	logic [CW-1:0]      den_x;
	logic [CW-1:0]      diff;
	logic               fit;
	logic signed [QW:0] sres;

	assign rem_x = CW'(rem_q);
	assign den_x = CW'(den_q);
	assign diff  = rem_x - den_x;
	assign fit   = rem_x >= den_x;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= KW'(QW);
			end else if (run_q) begin
				cnt_q <= cnt_q - KW'(1);
				if (cnt_q == KW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[NW-1];
			rem_q <= dividend[NW-1] ? NW'(-dividend) : NW'(dividend);
			den_q <= {divisor, {(QW-1){1'b0}}};
			q_q   <= '0;
		end else if (run_q) begin
			if (fit) begin
				rem_q <= diff[NW-1:0];
			end
			den_q <= den_q >> 1;
			q_q   <= {q_q[QW-2:0], fit};
		end
	end

	always_comb begin
		sres = neg_q ? -$signed({1'b0, q_q}) : $signed({1'b0, q_q});
		if (sres > (QW+1)'(32767)) begin
			quot = 16'sh7FFF;
		end else if (sres < -(QW+1)'(32768)) begin
			quot = -16'sh8000;
		end else begin
			quot = sres[15:0];
		end
	end

	assign done = done_q;

endmodule

[tb/sv/tb_top.sv]
// Self-checking testbench of the fractal gradient noise block: table loads, evaluations, checks.
`timescale 1ns / 1ps

module tb_top;
	import fgn_pkg::*;

	localparam int OCTAVE_LIMIT = 16;
	localparam logic [1:0] REG_UNUSED = 2'd3;
	localparam int SETTLE_CYCLES = 700;
	localparam int CYCLE_LIMIT = 2000000;

	typedef struct {
		logic        cmd;
		logic [7:0]  idx;
		logic [7:0]  val;
		logic [31:0] x;
		logic [31:0] y;
		logic        drain_first;
	} noise_req_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [79:0] s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	noise_req_t req_queue[$];
	logic [15:0] noise_expected[$];
	noise_req_t cur_req;
	logic [7:0] perm_copy[256];
	logic [4:0] octaves_m = OCTAVES_RESET;
	logic [15:0] persist_m = PERSISTENCE_RESET;
	logic [15:0] lacun_m = LACUNARITY_RESET;
	int errors = 0;
	int send_gap = 0;
	int recv_gap = 0;
	int hold_left = 0;
	int results_seen = 0;
	int cycles = 0;
	logic steady = 1'b0;
	logic next_valid;

	fractal_gradient_noise_2d #(.MAX_OCTAVES(OCTAVE_LIMIT)) DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic longint fade(longint t);
		longint t2, t3, d;
		t2 = (t * t) >>> 16;
		t3 = (t2 * t) >>> 16;
		d = ((15 * 65536 - 6 * t) * t) >>> 16;
		return (t3 * (10 * 65536 - d)) >>> 16;
	endfunction

	function automatic longint mix(longint a, longint b, longint t);
		return a + (t * (b - a)) / 65536;
	endfunction

	function automatic longint grad_dot(logic [7:0] h, longint dx, longint dy);
		return (h[0] ? -dx : dx) + (h[1] ? -dy : dy);
	endfunction

	function automatic logic [7:0] corner(logic [7:0] i, logic [7:0] j);
		logic [7:0] first;
		first = perm_copy[i];
		return perm_copy[8'(first + j)];
	endfunction

	function automatic longint layer(logic [31:0] x, logic [31:0] y, logic [63:0] freq);
		logic [63:0] px, py;
		logic [7:0] xi, yi;
		longint fx, fy, n00, n10, n01, n11, u, v;
		px = {{32{x[31]}}, x} * freq;
		py = {{32{y[31]}}, y} * freq;
		xi = px[39:32];
		yi = py[39:32];
		fx = longint'(px[31:16]);
		fy = longint'(py[31:16]);
		n00 = grad_dot(corner(xi, yi), fx, fy);
		n10 = grad_dot(corner(xi + 8'd1, yi), fx - 65536, fy);
		n01 = grad_dot(corner(xi, yi + 8'd1), fx, fy - 65536);
		n11 = grad_dot(corner(xi + 8'd1, yi + 8'd1), fx - 65536, fy - 65536);
		u = fade(fx);
		v = fade(fy);
		return mix(mix(n00, n10, u), mix(n01, n11, u), v);
	endfunction

	function automatic logic [15:0] fbm_sample(logic [31:0] x, logic [31:0] y);
		longint total, ampsum, q;
		logic [63:0] amp, freq;
		int layers;
		total = 0;
		ampsum = 0;
		amp = 64'd65536;
		freq = 64'd65536;
		layers = octaves_m;
		if (layers == 0) layers = 1;
		if (layers > OCTAVE_LIMIT) layers = OCTAVE_LIMIT;
		for (int k = 0; k < layers; k++) begin
			total += layer(x, y, freq) * longint'(amp);
			ampsum += longint'(amp);
			amp = (amp * persist_m) >> 12;
			if (amp > 64'hFFFF_FFFF) amp = 64'hFFFF_FFFF;
			freq = (freq * lacun_m) >> 12;
			if (freq > 64'hFFFF_FFFF) freq = 64'hFFFF_FFFF;
		end
		q = total / (2 * ampsum);
		if (q > 32767) q = 32767;
		if (q < -32768) q = -32768;
		return q[15:0];
	endfunction

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return 32'($urandom_range(0, 32'h1F_FFFF)) - 32'h10_0000;
			2: return {16'($urandom), 16'h0000};
			default: return {16'($urandom), ($urandom_range(0, 1) ? 16'hFFFF : 16'h0001)};
		endcase
	endfunction

	function automatic noise_req_t make_req(logic cmd, logic [7:0] idx, logic [7:0] val,
			logic [31:0] x, logic [31:0] y);
		noise_req_t r;
		r.cmd = cmd;
		r.idx = idx;
		r.val = val;
		r.x = x;
		r.y = y;
		r.drain_first = 1'b0;
		return r;
	endfunction

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	always @(posedge clk) if (arst_n) begin
		next_valid = s_tvalid;
		if (s_tvalid && s_tready) begin
			if (cur_req.cmd == CMD_LOAD)
				perm_copy[cur_req.idx] = cur_req.val;
			else
				noise_expected = {noise_expected, fbm_sample(cur_req.x, cur_req.y)};
			next_valid = 1'b0;
		end
		if (!next_valid) begin
			if (send_gap > 0) begin
				send_gap--;
			end else if (req_queue.size() > 0 &&
					!(req_queue[0].drain_first && noise_expected.size() > 0)) begin
				cur_req = req_queue.pop_front();
				next_valid = 1'b1;
				send_gap = steady ? 0 : idle_len();
				s_tdata <= {cur_req.y, cur_req.x, cur_req.val, cur_req.idx};
				s_tuser <= cur_req.cmd;
			end
		end
		s_tvalid <= next_valid;
	end

	always @(posedge clk) if (arst_n) begin
		if (m_tvalid && m_tready) begin
			if (noise_expected.size() == 0) begin
				errors++;
				$display("%0t: unexpected noise value, expected none, actual %h", $realtime, m_tdata);
			end else if (m_tdata !== noise_expected[0]) begin
				errors++;
				$display("%0t: noise value mismatch, expected %h, actual %h",
					$realtime, noise_expected[0], m_tdata);
			end
			if (noise_expected.size() > 0) void'(noise_expected.pop_front());
			results_seen++;
			if (results_seen == 300) hold_left = 2500;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (steady) begin
			m_tready <= 1'b1;
		end else if (recv_gap > 0) begin
			recv_gap--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			recv_gap = idle_len();
		end
	end

	task automatic settle();
		while (req_queue.size() > 0 || s_tvalid || noise_expected.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic reg_write(logic [1:0] idx, logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_OCTAVES: octaves_m = data[4:0];
			REG_PERSISTENCE: persist_m = data;
			REG_LACUNARITY: lacun_m = data;
			default: ;
		endcase
	endtask

	task automatic set_regs(logic [15:0] oct, logic [15:0] pers, logic [15:0] lac);
		reg_write(REG_OCTAVES, oct);
		reg_write(REG_PERSISTENCE, pers);
		reg_write(REG_UNUSED, 16'($urandom));
		reg_write(REG_LACUNARITY, lac);
		cfg_valid <= 1'b0;
	endtask

	task automatic push_evals(int n);
		for (int i = 0; i < n; i++)
			req_queue = {req_queue, make_req(CMD_EVAL, 8'($urandom), 8'($urandom),
				rand_coord(), rand_coord())};
	endtask

	initial begin
		noise_req_t r;
		logic [15:0] pers, lac;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < 256; i++)
			req_queue = {req_queue, make_req(CMD_LOAD, 8'(i), 8'($urandom), $urandom, $urandom)};
		req_queue = {req_queue, make_req(CMD_LOAD, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF)};
		req_queue = {req_queue, make_req(CMD_LOAD, 8'h00, 8'h00, 32'h0, 32'h0)};
		req_queue = {req_queue, make_req(CMD_EVAL, 8'hFF, 8'hFF, 32'h0, 32'h0)};
		req_queue = {req_queue, make_req(CMD_EVAL, 8'h00, 8'h00, 32'h7FFF_FFFF, 32'h7FFF_FFFF)};
		req_queue = {req_queue, make_req(CMD_EVAL, 8'h5A, 8'hA5, 32'h8000_0000, 32'h8000_0000)};
		req_queue = {req_queue, make_req(CMD_EVAL, 8'h00, 8'h00, 32'hFFFF_FFFF, 32'h0)};
		req_queue = {req_queue, make_req(CMD_EVAL, 8'h00, 8'h00, 32'h0, 32'hFFFF_FFFF)};
		req_queue = {req_queue, make_req(CMD_EVAL, 8'h00, 8'h00, 32'h0000_FFFF, 32'hFFFF_0000)};
		req_queue = {req_queue, make_req(CMD_EVAL, 8'h00, 8'h00, 32'h0001_0000, 32'h0001_0000)};
		req_queue = {req_queue, make_req(CMD_EVAL, 8'h00, 8'h00, 32'h0000_8000, 32'h0000_8000)};
		req_queue = {req_queue, make_req(CMD_EVAL, 8'h00, 8'h00, 32'h8000_0000, 32'h7FFF_FFFF)};
		settle();

		set_regs(16'd0, PERSISTENCE_RESET, LACUNARITY_RESET);
		push_evals(6);
		settle();
		set_regs(16'hFFFF, 16'hFFFF, 16'hFFFF);
		push_evals(12);
		settle();
		set_regs(16'd16, 16'd0, 16'd0);
		push_evals(12);
		settle();
		set_regs(16'd17, 16'd0, 16'hFFFF);
		push_evals(8);
		settle();

		for (int ph = 0; ph < 12; ph++) begin
			pers = $urandom_range(0, 7) == 0 ? 16'hFFFF : 16'($urandom_range(0, 16'h2000));
			lac = $urandom_range(0, 7) == 0 ? 16'h0000 : 16'($urandom);
			set_regs(ph == 5 ? 16'd16 : 16'($urandom_range(1, 4)) | (16'($urandom) & 16'hFFE0),
				pers, lac);
			steady = (ph % 4 == 1);
			for (int i = 0; i < (ph == 5 ? 40 : 80); i++) begin
				if ($urandom_range(0, 9) == 0)
					r = make_req(CMD_LOAD, 8'($urandom), 8'($urandom), $urandom, $urandom);
				else
					r = make_req(CMD_EVAL, 8'($urandom), 8'($urandom), rand_coord(), rand_coord());
				r.drain_first = ($urandom_range(0, 49) == 0);
				req_queue = {req_queue, r};
			end
			settle();
			steady = 1'b0;
		end

		if (errors == 0 && noise_expected.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

[sim.f]
sv/fgn_pkg.sv
sv/fgn_perm_ram.sv
sv/fgn_mul.sv
sv/fgn_div.sv
sv/fractal_gradient_noise_2d.sv
tb/sv/tb_top.sv
